FILE: rtl/core/apcs_pkg.sv
package apcs_pkg;

  localparam int HISTORY_DEPTH = 16;
  localparam int RING_AW       = $clog2(HISTORY_DEPTH);
  localparam int VALUE_W       = 12;
  localparam int SUM_W         = VALUE_W + RING_AW;
  localparam int GRACE_W       = 16;
  localparam int WATT_W        = 10;
  localparam int CMP_W         = VALUE_W + 2;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_TDATA_W   = 40;

  localparam logic [CMP_W-1:0]   LOWER_BASE_WATTS = CMP_W'(50);
  localparam logic [SUM_W-1:0]   SUM_MAX          = SUM_W'(HISTORY_DEPTH * 4095);

  localparam logic [GRACE_W-1:0] GRACE_RST = GRACE_W'(10);
  localparam logic [WATT_W-1:0]  TOL_RST   = WATT_W'(5);
  localparam logic [WATT_W-1:0]  STEP_RST  = WATT_W'(5);
  localparam logic [WATT_W-1:0]  GAP_RST   = WATT_W'(5);
  localparam logic [VALUE_W-1:0] UPPER_RST = VALUE_W'(400);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRACE = 3'd0,
    CFG_TOL   = 3'd1,
    CFG_STEP  = 3'd2,
    CFG_GAP   = 3'd3,
    CFG_UPPER = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_t;

  // short limit is the long limit less the gap, floored at zero
  function automatic logic [VALUE_W-1:0] short_of(input logic [VALUE_W-1:0] lng,
                                                 input logic [WATT_W-1:0]  gap);
    logic [VALUE_W-1:0] gap_ext;
    gap_ext = VALUE_W'(gap);
    return (lng >= gap_ext) ? (lng - gap_ext) : '0;
  endfunction

endpackage

FILE: rtl/core/apcs_ram.sv
module apcs_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: rtl/core/averaged_power_cap_stepper_core.sv
// channel | direction | handshake             | payload
// in_     | slave     | in_tvalid / in_tready   | tuser op, tdata value_watts
// out_    | master    | out_tvalid / out_tready | tuser limit_write, tdata limits/mean/grace
// cfg_    | slave     | cfg_valid / cfg_ready   | cfg_addr register index, cfg_data value
//
// one item per cycle sustained while out_tready does not stall; after acceptance a result reaches out_tvalid
// (ring read in the accept cycle, update and compare in the next, then the output register).
// the ring RAM reads the next slot for both possible ring positions so the previous item's
// sampling decision never holds up acceptance.
// rst_n is synchronous; ring slots read as zero until written (per-slot valid bits), no sweep.
// a stalled out_tready holds the update stage, which in turn drops in_tready.
module averaged_power_cap_stepper_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [apcs_pkg::IN_TDATA_W-1:0]     in_tdata,   // [11:0] value_watts
  input  logic                                in_tuser,   // [0] op
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [11:0] long_limit_watts, [23:12] short_limit_watts, [35:24] average_watts,
  // [36] grace_active
  output logic [apcs_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tuser,  // [0] limit_write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [apcs_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [apcs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW = apcs_pkg::RING_AW;
  localparam int VW = apcs_pkg::VALUE_W;
  localparam int SW = apcs_pkg::SUM_W;
  localparam int GW = apcs_pkg::GRACE_W;
  localparam int WW = apcs_pkg::WATT_W;
  localparam int CW = apcs_pkg::CMP_W;

  // configuration
  logic [GW-1:0] grace_ticks_r;
  logic [WW-1:0] tol_r, step_r, gap_r;
  logic [VW-1:0] upper_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grace_ticks_r <= apcs_pkg::GRACE_RST;
      tol_r         <= apcs_pkg::TOL_RST;
      step_r        <= apcs_pkg::STEP_RST;
      gap_r         <= apcs_pkg::GAP_RST;
      upper_r       <= apcs_pkg::UPPER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        apcs_pkg::CFG_GRACE: grace_ticks_r <= cfg_data;
        apcs_pkg::CFG_TOL:   tol_r         <= cfg_data[WW-1:0];
        apcs_pkg::CFG_STEP:  step_r        <= cfg_data[WW-1:0];
        apcs_pkg::CFG_GAP:   gap_r         <= cfg_data[WW-1:0];
        apcs_pkg::CFG_UPPER: upper_r       <= cfg_data[VW-1:0];
        default: ;
      endcase
    end
  end

  // scalar state
  logic [AW-1:0] pos_r, pos_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [VW-1:0] target_r, target_nxt;
  logic [GW-1:0] grace_r, grace_nxt;
  logic [VW-1:0] long_r, long_nxt;
  logic [VW-1:0] short_r, short_nxt;
  logic [apcs_pkg::HISTORY_DEPTH-1:0] slot_valid_r;

  // update stage
  logic          s1_v_r;
  logic          s1_op_r;
  logic [VW-1:0] s1_val_r;
  logic [AW-1:0] s1_addr_a_r;
  logic          s1_fire;
  logic          in_acc;

  // write that lands on the same edge as a read
  logic          fwd_v_r;
  logic [AW-1:0] fwd_addr_r;
  logic [VW-1:0] fwd_data_r;

  logic          out_v_r;
  logic          out_write_r;
  logic [apcs_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic          ring_we;
  logic [AW-1:0] ring_waddr;
  logic [VW-1:0] rdata_a, rdata_b;

  assign s1_fire   = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_fire;
  assign in_acc    = in_tvalid && in_tready;

  apcs_ram #(
    .WIDTH (VW),
    .DEPTH (apcs_pkg::HISTORY_DEPTH)
  ) u_ring (
    .clk     (clk),
    .we      (ring_we),
    .waddr   (ring_waddr),
    .wdata   (s1_val_r),
    .re      (in_acc),
    .raddr_a (pos_r + AW'(1)),
    .raddr_b (pos_r + AW'(2)),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  logic [AW-1:0] slot;
  logic [VW-1:0] old_sample;
  logic [VW-1:0] avg_new;
  logic [CW-1:0] avg_c, tgt_c, tol_c, stp_c, gap_c, up_c;
  logic          wrote;
  logic          sampling;

  always_comb begin
    slot     = pos_r + AW'(1);
    sampling = (s1_op_r == apcs_pkg::OP_TICK) && (grace_r == '0);
    // previous item may have moved the position after this read was issued
    if (!slot_valid_r[slot]) begin
      old_sample = '0;
    end else if (fwd_v_r && (fwd_addr_r == slot)) begin
      old_sample = fwd_data_r;
    end else if (slot != s1_addr_a_r) begin
      old_sample = rdata_b;
    end else begin
      old_sample = rdata_a;
    end

    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    target_nxt = target_r;
    grace_nxt  = grace_r;
    long_nxt   = long_r;
    short_nxt  = short_r;
    wrote      = 1'b0;
    ring_we    = 1'b0;
    ring_waddr = slot;

    avg_new = VW'((sum_r - SW'(old_sample) + SW'(s1_val_r)) >> AW);
    avg_c   = CW'(avg_new);
    tgt_c   = CW'(target_r);
    tol_c   = CW'(tol_r);
    stp_c   = CW'(step_r);
    gap_c   = CW'(gap_r);
    up_c    = CW'(upper_r);

    if (s1_op_r == apcs_pkg::OP_SET) begin
      target_nxt = s1_val_r;
      long_nxt   = s1_val_r;
      short_nxt  = apcs_pkg::short_of(s1_val_r, gap_r);
      grace_nxt  = grace_ticks_r;
      wrote      = 1'b1;
    end else if (!sampling) begin
      grace_nxt = grace_r - GW'(1);
    end else begin
      ring_we = s1_fire;
      pos_nxt = slot;
      sum_nxt = sum_r - SW'(old_sample) + SW'(s1_val_r);
      if (avg_c > tgt_c + tol_c) begin
        if (tgt_c >= stp_c + apcs_pkg::LOWER_BASE_WATTS + gap_c) begin
          long_nxt  = VW'(tgt_c - stp_c);
          short_nxt = apcs_pkg::short_of(VW'(tgt_c - stp_c), gap_r);
          grace_nxt = grace_ticks_r;
          wrote     = 1'b1;
        end
      end else if (avg_c + tol_c < tgt_c) begin
        if (tgt_c + stp_c <= up_c) begin
          long_nxt  = VW'(tgt_c + stp_c);
          short_nxt = apcs_pkg::short_of(VW'(tgt_c + stp_c), gap_r);
          grace_nxt = grace_ticks_r;
          wrote     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      sum_r        <= '0;
      target_r     <= '0;
      grace_r      <= '0;
      long_r       <= '0;
      short_r      <= '0;
      slot_valid_r <= '0;
      s1_v_r       <= 1'b0;
      fwd_v_r      <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      if (s1_fire) begin
        pos_r    <= pos_nxt;
        sum_r    <= sum_nxt;
        target_r <= target_nxt;
        grace_r  <= grace_nxt;
        long_r   <= long_nxt;
        short_r  <= short_nxt;
        out_v_r  <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (ring_we) begin
        slot_valid_r[ring_waddr] <= 1'b1;
      end
      if (in_acc) begin
        s1_v_r  <= 1'b1;
        fwd_v_r <= ring_we;
      end else if (s1_fire) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r     <= in_tuser;
      s1_val_r    <= in_tdata[VW-1:0];
      s1_addr_a_r <= pos_r + AW'(1);
      fwd_addr_r  <= ring_waddr;
      fwd_data_r  <= s1_val_r;
    end
    if (s1_fire) begin
      out_write_r <= wrote;
      out_data_r  <= {3'b000, (grace_nxt != '0), sum_nxt[SW-1:AW], short_nxt, long_nxt};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_write_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_short_le_long: assert property (@(posedge clk) disable iff (!rst_n)
    short_r <= long_r)
    else $error("short limit above long limit");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= apcs_pkg::SUM_MAX)
    else $error("ring sum out of range");

  a_pos_adv: assert property (@(posedge clk) disable iff (!rst_n)
    ring_we |=> pos_r == $past(pos_r) + AW'(1))
    else $error("ring position did not follow sample write");

  a_grace_load: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && wrote) |=> grace_r == $past(grace_ticks_r))
    else $error("grace not restarted on limit write");
`endif

endmodule

FILE: tb/averaged_power_cap_stepper_core_test.sv
`timescale 1ns / 1ps

typedef struct packed {
  bit        limit_write;
  bit [11:0] long_limit;
  bit [11:0] short_limit;
  bit [11:0] average;
  bit        grace_active;
} cap_result_t;

class power_cap_scoreboard;
  cap_result_t expected_q[$];
  int          errors;

  // register copies
  bit [15:0] grace_reload;
  bit [9:0]  tolerance;
  bit [9:0]  step;
  bit [9:0]  gap;
  bit [11:0] upper;

  // block state
  bit [11:0] ring[apcs_pkg::HISTORY_DEPTH];
  bit [apcs_pkg::RING_AW-1:0] slot;
  bit [15:0] ring_sum;
  bit [11:0] target;
  bit [11:0] long_lim;
  bit [11:0] short_lim;
  bit [15:0] grace_left;

  function new();
    errors       = 0;
    grace_reload = 16'd10;
    tolerance    = 10'd5;
    step         = 10'd5;
    gap          = 10'd5;
    upper        = 12'd400;
    foreach (ring[i]) ring[i] = '0;
    slot       = '0;
    ring_sum   = '0;
    target     = '0;
    long_lim   = '0;
    short_lim  = '0;
    grace_left = '0;
  endfunction

  function void write_reg(apcs_pkg::cfg_idx_t idx, bit [15:0] value);
    case (idx)
      apcs_pkg::CFG_GRACE: grace_reload = value;
      apcs_pkg::CFG_TOL:   tolerance    = value[9:0];
      apcs_pkg::CFG_STEP:  step         = value[9:0];
      apcs_pkg::CFG_GAP:   gap          = value[9:0];
      apcs_pkg::CFG_UPPER: upper        = value[11:0];
      default: ;
    endcase
  endfunction

  function void issue_limits(int watts);
    long_lim  = watts[11:0];
    short_lim = (int'(long_lim) >= int'(gap)) ? long_lim - 12'(gap) : 12'd0;
  endfunction

  function void note_item(apcs_pkg::op_t op, bit [11:0] value);
    cap_result_t res;
    int mean_w;
    int tgt_w;
    int lower_w;
    res.limit_write = 1'b0;
    if (op == apcs_pkg::OP_SET) begin
      issue_limits(int'(value));
      target          = value;
      grace_left      = grace_reload;
      res.limit_write = 1'b1;
    end else if (grace_left != 0) begin
      grace_left = grace_left - 16'd1;
    end else begin
      // slot advances before the write
      slot       = slot + 1'b1;
      ring_sum   = 16'(int'(ring_sum) - int'(ring[slot]) + int'(value));
      ring[slot] = value;
      mean_w  = int'(ring_sum) / apcs_pkg::HISTORY_DEPTH;
      tgt_w   = int'(target);
      lower_w = 50 + int'(gap);
      if (mean_w - int'(tolerance) > tgt_w) begin
        if (tgt_w - int'(step) >= lower_w) begin
          issue_limits(tgt_w - int'(step));
          grace_left      = grace_reload;
          res.limit_write = 1'b1;
        end
      end else if (mean_w + int'(tolerance) < tgt_w) begin
        if (tgt_w + int'(step) <= int'(upper)) begin
          issue_limits(tgt_w + int'(step));
          grace_left      = grace_reload;
          res.limit_write = 1'b1;
        end
      end
    end
    res.long_limit   = long_lim;
    res.short_limit  = short_lim;
    res.average      = 12'(int'(ring_sum) / apcs_pkg::HISTORY_DEPTH);
    res.grace_active = (grace_left != 0);
    expected_q.push_back(res);
  endfunction

  function void check_result(bit limit_write, bit [39:0] data);
    cap_result_t exp_r;
    cap_result_t got;
    if (expected_q.size() == 0) begin
      $error("result transaction with nothing expected: tuser %0d tdata %h", limit_write, data);
      errors++;
      return;
    end
    exp_r            = expected_q.pop_front();
    got.limit_write  = limit_write;
    got.long_limit   = data[11:0];
    got.short_limit  = data[23:12];
    got.average      = data[35:24];
    got.grace_active = data[36];
    if (got.limit_write != exp_r.limit_write) begin
      $error("limit_write: expected %0d, got %0d", exp_r.limit_write, got.limit_write);
      errors++;
    end
    if (got.long_limit != exp_r.long_limit) begin
      $error("long_limit_watts: expected %0d, got %0d", exp_r.long_limit, got.long_limit);
      errors++;
    end
    if (got.short_limit != exp_r.short_limit) begin
      $error("short_limit_watts: expected %0d, got %0d", exp_r.short_limit, got.short_limit);
      errors++;
    end
    if (got.average != exp_r.average) begin
      $error("average_watts: expected %0d, got %0d", exp_r.average, got.average);
      errors++;
    end
    if (got.grace_active != exp_r.grace_active) begin
      $error("grace_active: expected %0d, got %0d", exp_r.grace_active, got.grace_active);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function bit all_clean();
    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
    end
    return (errors == 0) && (expected_q.size() == 0);
  endfunction
endclass

module averaged_power_cap_stepper_core_test;

  localparam int CYCLE_LIMIT  = 250000;
  localparam int PHASE_ITEMS  = 173;
  localparam int PHASE_COUNT  = 8;
  localparam int HOLD_CYCLES  = 80;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [apcs_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                             in_tuser = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [apcs_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tuser;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [apcs_pkg::CFG_IDX_W-1:0]   cfg_addr = '0;
  logic [apcs_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  power_cap_scoreboard sb = new();

  bit          stall_enable = 1'b0;
  bit          hold_off_req = 1'b0;
  bit [11:0]   last_target = 12'd0;
  int unsigned cycle_count = 0;

  averaged_power_cap_stepper_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // result side: checks every transaction and stalls in bursts
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
        sb.check_result(out_tuser, out_tdata);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (stall_enable && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // leaves in_tvalid high; the caller lowers it or offers the next item
  task automatic send_item(input apcs_pkg::op_t op, input logic [11:0] value);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, value};
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_item(op, value);
  endtask

  task automatic pause_input(input int cycles);
    in_tvalid <= 1'b0;
    in_tuser  <= 1'($urandom_range(0, 1));
    in_tdata  <= 16'($urandom_range(0, 4095));
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input logic [15:0] grace, input logic [15:0] tol,
                              input logic [15:0] stp, input logic [15:0] gap,
                              input logic [15:0] upper);
    logic [15:0]        vals[5];
    apcs_pkg::cfg_idx_t idx;
    vals = '{grace, tol, stp, gap, upper};
    for (int i = 0; i < 5; i++) begin
      idx = apcs_pkg::cfg_idx_t'(i);
      cfg_valid <= 1'b1;
      cfg_addr  <= idx;
      cfg_data  <= vals[i];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      sb.write_reg(idx, vals[i]);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_watts(input int hi_rand, input int extreme);
    if ($urandom_range(0, 3) == 0) begin
      return $urandom_range(0, 1) ? 16'(extreme) : 16'd0;
    end
    return 16'($urandom_range(0, hi_rand));
  endfunction

  task automatic random_config();
    logic [15:0] grace;
    logic [15:0] upper;
    case ($urandom_range(0, 9))
      0:       grace = 16'd0;
      1:       grace = 16'hFFFF;
      default: grace = 16'($urandom_range(0, 12));
    endcase
    upper = ($urandom_range(0, 4) == 0) ? pick_watts(0, 4095)
                                         : 16'($urandom_range(100, 4095));
    write_config(grace, pick_watts(40, 1023), pick_watts(60, 1023),
                 pick_watts(60, 1023), upper);
  endtask

  task automatic random_item();
    int reading;
    if ($urandom_range(0, 99) < 8) begin
      last_target = $urandom_range(0, 1) ? 12'($urandom_range(0, 4095))
                                         : 12'($urandom_range(40, 600));
      send_item(apcs_pkg::OP_SET, last_target);
    end else if ($urandom_range(0, 9) < 6) begin
      // readings around the target drive the stepping decisions
      reading = int'(last_target) + $urandom_range(0, 600) - 300;
      if (reading < 0) reading = 0;
      if (reading > 4095) reading = 4095;
      send_item(apcs_pkg::OP_TICK, 12'(reading));
    end else begin
      send_item(apcs_pkg::OP_TICK, 12'($urandom_range(0, 4095)));
    end
  endtask

  task automatic run_phase(input int count, input bit allow_idle);
    int idle_rate;
    idle_rate = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) idle_rate = allow_idle ? $urandom_range(0, 3) : 0;
      random_item();
      if (idle_rate != 0 && $urandom_range(0, 9) < idle_rate) begin
        pause_input($urandom_range(1, 6));
      end
    end
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: negative step target, saturated short limit, grace countdown
    send_item(apcs_pkg::OP_TICK, 12'd4095);
    send_item(apcs_pkg::OP_TICK, 12'd0);
    send_item(apcs_pkg::OP_SET, 12'd0);
    send_item(apcs_pkg::OP_SET, 12'd4095);
    send_item(apcs_pkg::OP_TICK, 12'd4095);
    drain();

    // zero grace, widest gap and step, zero tolerance
    write_config(16'd0, 16'd0, 16'd1023, 16'd1023, 16'd4095);
    send_item(apcs_pkg::OP_SET, 12'd30);
    send_item(apcs_pkg::OP_TICK, 12'd0);
    send_item(apcs_pkg::OP_SET, 12'd2000);
    send_item(apcs_pkg::OP_TICK, 12'd4095);
    send_item(apcs_pkg::OP_TICK, 12'd0);
    drain();

    // longest grace
    write_config(16'hFFFF, 16'd1023, 16'd0, 16'd0, 16'd0);
    send_item(apcs_pkg::OP_SET, 12'd100);
    send_item(apcs_pkg::OP_TICK, 12'd4095);
    send_item(apcs_pkg::OP_TICK, 12'd4095);
    drain();

    // lower bound above upper bound: no step up can be issued, a step down still can
    write_config(16'd1, 16'd0, 16'd10, 16'd0, 16'd0);
    send_item(apcs_pkg::OP_SET, 12'd100);
    send_item(apcs_pkg::OP_TICK, 12'd5);
    send_item(apcs_pkg::OP_TICK, 12'd0);
    send_item(apcs_pkg::OP_TICK, 12'd4095);
    drain();

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      stall_enable = (ph != PHASE_COUNT - 1);
      random_config();
      if (ph == 1) hold_off_req = 1'b1;
      run_phase(PHASE_ITEMS, ph != PHASE_COUNT - 1);
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.all_clean()) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/apcs_pkg.sv
rtl/core/apcs_ram.sv
rtl/core/averaged_power_cap_stepper_core.sv
tb/averaged_power_cap_stepper_core_test.sv
